// ===== sv/fda_pkg.sv =====
// ============================================================================
// fda_pkg
// Shared types and constants of the fixed-point to decimal text converter.
// ============================================================================
`default_nettype none

package fda_pkg;

    localparam int VALUE_W         = 64;
    localparam int FRAC_BITS       = 32;
    localparam int INT_BITS        = VALUE_W - FRAC_BITS;
    localparam int INT_DIGITS      = ((INT_BITS * 1233) >> 12) + 1;
    localparam int BCD_W           = 4 * INT_DIGITS;
    localparam int BIT_CNT_W       = $clog2(INT_BITS + 1);
    localparam int DIG_CNT_W       = $clog2(INT_DIGITS + 1);
    localparam int MAX_FRAC_DIGITS = 15;
    localparam int CFG_W           = 4;
    localparam int PREC_W          = ($clog2(MAX_FRAC_DIGITS + 1) > CFG_W) ?
                                     $clog2(MAX_FRAC_DIGITS + 1) : CFG_W;
    localparam int CHAR_W          = 8;

    localparam logic [CFG_W-1:0]  CFG_RESET  = 4'd3;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_INT,
        S_POINT,
        S_FRAC
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_dab_ctl;

    typedef struct packed {
        logic       busy;
        logic [3:0] top;
    } t_dab_sts;

    typedef struct packed {
        logic load;
        logic step;
    } t_frac_ctl;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] digit);
        return CHAR_ZERO + {{(CHAR_W-4){1'b0}}, digit};
    endfunction

endpackage

`default_nettype wire

// ===== sv/fda_dabble.sv =====
// ============================================================================
// fda_dabble
// Iterative binary to BCD converter, one bit per cycle, with digit shift-out.
// ============================================================================
`default_nettype none

module fda_dabble (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fda_pkg::t_dab_ctl             i_ctl,
    input  wire logic [fda_pkg::INT_BITS-1:0]  i_bin,
    output fda_pkg::t_dab_sts                  o_sts
);

    logic [fda_pkg::INT_BITS-1:0]  r_bin;
    logic [fda_pkg::BCD_W-1:0]     r_bcd;
    logic [fda_pkg::BIT_CNT_W-1:0] r_cnt;
    logic [fda_pkg::BCD_W-1:0]     w_adj;

    always_comb begin
        for (int d = 0; d < fda_pkg::INT_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= fda_pkg::BIT_CNT_W'(fda_pkg::INT_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - fda_pkg::BIT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_cnt != '0) begin
            r_bcd <= {w_adj[fda_pkg::BCD_W-2:0], r_bin[fda_pkg::INT_BITS-1]};
            r_bin <= {r_bin[fda_pkg::INT_BITS-2:0], 1'b0};
        end else if (i_ctl.shift) begin
            r_bcd <= {r_bcd[fda_pkg::BCD_W-5:0], 4'b0000};
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.top  = r_bcd[fda_pkg::BCD_W-1 -: 4];

endmodule

`default_nettype wire

// ===== sv/fda_frac_unit.sv =====
// ============================================================================
// fda_frac_unit
// Fraction register with a times-ten step that yields one decimal digit.
// ============================================================================
`default_nettype none

module fda_frac_unit (
    input  wire logic                           i_clk,
    input  wire fda_pkg::t_frac_ctl             i_ctl,
    input  wire logic [fda_pkg::FRAC_BITS-1:0]  i_frac,
    output logic [3:0]                          o_digit
);

    logic [fda_pkg::FRAC_BITS-1:0] r_frac;
    logic [fda_pkg::FRAC_BITS+3:0] w_prod;

    assign w_prod  = {r_frac, 3'b000} + {3'b000, r_frac, 1'b0};
    assign o_digit = w_prod[fda_pkg::FRAC_BITS+3 -: 4];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_frac <= i_frac;
        end else if (i_ctl.step) begin
            r_frac <= w_prod[fda_pkg::FRAC_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/fixed_to_decimal_ascii_core.sv =====
// ============================================================================
// fixed_to_decimal_ascii_core
// Converts a signed fixed-point number into its truncated decimal ASCII text.
// ============================================================================
//  Channel | Direction | Signals                              | Transaction
//  in      | sink      | i_in_valid, o_in_ready, i_value      | one number
//  out     | source    | o_out_valid, i_out_ready,            | one character
//          |           | o_char_code, o_last                  |
//  cfg     | sink      | i_cfg_valid, o_cfg_ready, i_cfg_data | frac_digits write
//
// After a number is taken, the bit-serial BCD converter runs, leading zero
// digits are dropped, then one character is produced per cycle when the
// output is not stalled. The next number is taken only in the idle state,
// once the final character of the last number has been loaded.
// Synchronous active-low reset sets frac_digits to 3 and empties the output.
// A stall on the output holds the current character and pauses the sequencer.
// A new number is accepted while the final character still waits to be taken.
`default_nettype none

module fixed_to_decimal_ascii_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [fda_pkg::VALUE_W-1:0] i_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [fda_pkg::CHAR_W-1:0]             o_char_code,
    output logic                                   o_last,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [fda_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int FCNT_W = fda_pkg::PREC_W;

    fda_pkg::t_state               r_state, n_state;
    logic                          r_neg;
    logic [fda_pkg::DIG_CNT_W-1:0] r_dig_left;
    logic [FCNT_W-1:0]             r_frac_left;
    logic [fda_pkg::CFG_W-1:0]     r_frac_digits;
    logic                          r_out_valid;
    logic [fda_pkg::CHAR_W-1:0]    r_char;
    logic                          r_last;

    logic [fda_pkg::VALUE_W-1:0]   w_mag;
    logic [FCNT_W-1:0]             w_prec_ext;
    logic [FCNT_W-1:0]             w_prec;
    logic                          w_can_load;
    logic                          w_accept;
    logic                          w_out_load;
    logic [fda_pkg::CHAR_W-1:0]    w_out_char;
    logic                          w_out_last;
    logic                          w_dig_dec;
    logic                          w_frac_set;
    logic                          w_frac_dec;
    fda_pkg::t_dab_ctl             w_dab_ctl;
    fda_pkg::t_dab_sts             w_dab_sts;
    fda_pkg::t_frac_ctl            w_frac_ctl;
    logic [3:0]                    w_frac_digit;

    assign w_mag = i_value[fda_pkg::VALUE_W-1] ?
                   (~i_value + fda_pkg::VALUE_W'(1)) : i_value;

    assign w_prec_ext = FCNT_W'(r_frac_digits);
    assign w_prec     = (w_prec_ext > FCNT_W'(fda_pkg::MAX_FRAC_DIGITS)) ?
                        FCNT_W'(fda_pkg::MAX_FRAC_DIGITS) : w_prec_ext;

    assign w_can_load = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    fda_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dab_ctl),
        .i_bin   (w_mag[fda_pkg::VALUE_W-1:fda_pkg::FRAC_BITS]),
        .o_sts   (w_dab_sts)
    );

    fda_frac_unit u_frac (
        .i_clk   (i_clk),
        .i_ctl   (w_frac_ctl),
        .i_frac  (w_mag[fda_pkg::FRAC_BITS-1:0]),
        .o_digit (w_frac_digit)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fda_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = fda_pkg::S_CONV;
                end
            end
            fda_pkg::S_CONV: begin
                if (!w_dab_sts.busy) begin
                    n_state = fda_pkg::S_SKIP;
                end
            end
            fda_pkg::S_SKIP: begin
                if (!(w_dab_sts.top == 4'd0 && r_dig_left > fda_pkg::DIG_CNT_W'(1))) begin
                    n_state = r_neg ? fda_pkg::S_SIGN : fda_pkg::S_INT;
                end
            end
            fda_pkg::S_SIGN: begin
                if (w_can_load) begin
                    n_state = fda_pkg::S_INT;
                end
            end
            fda_pkg::S_INT: begin
                if (w_can_load && r_dig_left == fda_pkg::DIG_CNT_W'(1)) begin
                    n_state = (w_prec == '0) ? fda_pkg::S_IDLE : fda_pkg::S_POINT;
                end
            end
            fda_pkg::S_POINT: begin
                if (w_can_load) begin
                    n_state = fda_pkg::S_FRAC;
                end
            end
            fda_pkg::S_FRAC: begin
                if (w_can_load && r_frac_left == FCNT_W'(1)) begin
                    n_state = fda_pkg::S_IDLE;
                end
            end
            default: n_state = fda_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        w_dab_ctl       = '0;
        w_frac_ctl      = '0;
        w_out_load      = 1'b0;
        w_out_char      = fda_pkg::digit_char(w_dab_sts.top);
        w_out_last      = 1'b0;
        w_dig_dec       = 1'b0;
        w_frac_set      = 1'b0;
        w_frac_dec      = 1'b0;
        unique case (r_state)
            fda_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                w_dab_ctl.load  = i_in_valid;
                w_frac_ctl.load = i_in_valid;
            end
            fda_pkg::S_CONV: begin
            end
            fda_pkg::S_SKIP: begin
                if (w_dab_sts.top == 4'd0 && r_dig_left > fda_pkg::DIG_CNT_W'(1)) begin
                    w_dab_ctl.shift = 1'b1;
                    w_dig_dec       = 1'b1;
                end
            end
            fda_pkg::S_SIGN: begin
                w_out_load = w_can_load;
                w_out_char = fda_pkg::CHAR_MINUS;
            end
            fda_pkg::S_INT: begin
                w_out_load      = w_can_load;
                w_out_char      = fda_pkg::digit_char(w_dab_sts.top);
                w_out_last      = (r_dig_left == fda_pkg::DIG_CNT_W'(1)) && (w_prec == '0);
                w_dab_ctl.shift = w_can_load;
                w_dig_dec       = w_can_load;
            end
            fda_pkg::S_POINT: begin
                w_out_load = w_can_load;
                w_out_char = fda_pkg::CHAR_POINT;
                w_frac_set = w_can_load;
            end
            fda_pkg::S_FRAC: begin
                w_out_load      = w_can_load;
                w_out_char      = fda_pkg::digit_char(w_frac_digit);
                w_out_last      = (r_frac_left == FCNT_W'(1));
                w_frac_ctl.step = w_can_load;
                w_frac_dec      = w_can_load;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fda_pkg::S_IDLE;
            r_out_valid   <= 1'b0;
            r_frac_digits <= fda_pkg::CFG_RESET;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_frac_digits <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg      <= i_value[fda_pkg::VALUE_W-1];
            r_dig_left <= fda_pkg::DIG_CNT_W'(fda_pkg::INT_DIGITS);
        end else if (w_dig_dec) begin
            r_dig_left <= r_dig_left - fda_pkg::DIG_CNT_W'(1);
        end
        if (w_frac_set) begin
            r_frac_left <= w_prec;
        end else if (w_frac_dec) begin
            r_frac_left <= r_frac_left - FCNT_W'(1);
        end
        if (w_out_load) begin
            r_char <= w_out_char;
            r_last <= w_out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== sv/fda_checker.sv =====
// ============================================================================
// fda_checker
// Port-level checks of the decimal text converter, bound to the top level.
// ============================================================================
`default_nettype none

module fda_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_ready,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [fda_pkg::CHAR_W-1:0]        o_char_code,
    input wire logic                              o_last
);

    logic w_is_digit;

    assign w_is_digit = (o_char_code >= fda_pkg::CHAR_ZERO) &&
                        (o_char_code <= fda_pkg::CHAR_NINE);

    // A stalled character transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_char_code) && $stable(o_last)))
        else $error("output transaction changed while stalled");

    // Once a number is taken, the converter is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // Every character is a digit, a minus sign or a decimal point.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (w_is_digit || o_char_code == fda_pkg::CHAR_MINUS ||
                         o_char_code == fda_pkg::CHAR_POINT))
        else $error("character outside the decimal text set");

    // The text of a number always ends in a digit.
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> w_is_digit)
        else $error("final character is not a digit");

endmodule

bind fixed_to_decimal_ascii_core fda_checker u_fda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);

`default_nettype wire

// ===== tb/sv/tb_fixed_to_decimal_ascii_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_fixed_to_decimal_ascii_core
// Self-checking bench for the fixed-point to decimal text converter.
// Numbers are queued by a sequencer and offered by a clocked driver. A monitor
// predicts the character stream of every accepted number with its own
// formatter, then checks each character and its last flag in order. Runs
// cover the reset precision, zero and full precision, random settings, random
// gaps on both sides and one long output stall that backs up the input.
// ============================================================================

module tb_fixed_to_decimal_ascii_core;

    typedef struct {
        logic [fda_pkg::CHAR_W-1:0] code;
        logic                       last;
    } t_char_rec;

    localparam logic [fda_pkg::CFG_W-1:0] FRAC_DIGITS_AT_RESET = 4'd3;
    localparam int                        NUM_PHASES           = 8;
    localparam int                        NUMBERS_PER_PHASE    = 40;
    localparam int                        SETTLE_CYCLES        = 5;
    localparam int                        STALL_CYCLES         = 400;
    localparam int                        MAX_PRINTED          = 200;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    logic signed [fda_pkg::VALUE_W-1:0] i_value     = '0;
    logic                               i_out_ready = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic [fda_pkg::CFG_W-1:0]          i_cfg_data  = '0;
    logic                               o_in_ready;
    logic                               o_out_valid;
    logic [fda_pkg::CHAR_W-1:0]         o_char_code;
    logic                               o_last;
    logic                               o_cfg_ready;

    logic [fda_pkg::VALUE_W-1:0] numbers_to_send [$];
    t_char_rec                   expected_chars [$];
    logic [fda_pkg::CFG_W-1:0]   frac_cfg         = FRAC_DIGITS_AT_RESET;
    int                          numbers_sent     = 0;
    int                          numbers_accepted = 0;
    int                          numbers_checked  = 0;
    int                          char_pos         = 0;
    int                          mismatch_count   = 0;
    int                          tx_idle_pct      = 6;
    int                          rx_idle_pct      = 49;
    bit                          rx_hold          = 1'b0;

    fixed_to_decimal_ascii_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void format_decimal(input logic [fda_pkg::VALUE_W-1:0] raw,
                                           input logic [fda_pkg::CFG_W-1:0]   digits);
        logic [fda_pkg::VALUE_W-1:0] mag;
        logic [fda_pkg::VALUE_W-1:0] ipart;
        logic [fda_pkg::VALUE_W-1:0] frac;
        logic [fda_pkg::VALUE_W-1:0] frac_mask;
        logic [fda_pkg::CHAR_W-1:0]  text [$];
        logic [3:0]                  int_digits [$];
        int                          prec;
        t_char_rec                   rec;

        frac_mask = (64'd1 << fda_pkg::FRAC_BITS) - 64'd1;
        mag       = raw[fda_pkg::VALUE_W-1] ? (~raw + 64'd1) : raw;
        ipart     = mag >> fda_pkg::FRAC_BITS;
        frac      = mag & frac_mask;
        prec      = (digits > fda_pkg::MAX_FRAC_DIGITS) ?
                    fda_pkg::MAX_FRAC_DIGITS : int'(digits);

        if (raw[fda_pkg::VALUE_W-1]) begin
            text.push_back(fda_pkg::CHAR_MINUS);
        end
        do begin
            int_digits.push_front(4'(ipart % 64'd10));
            ipart = ipart / 64'd10;
        end while (ipart != 64'd0);
        foreach (int_digits[k]) begin
            text.push_back(fda_pkg::CHAR_ZERO + fda_pkg::CHAR_W'(int_digits[k]));
        end
        if (prec > 0) begin
            text.push_back(fda_pkg::CHAR_POINT);
            for (int j = 0; j < prec; j++) begin
                frac = frac * 64'd10;
                text.push_back(fda_pkg::CHAR_ZERO +
                               fda_pkg::CHAR_W'(frac >> fda_pkg::FRAC_BITS));
                frac = frac & frac_mask;
            end
        end
        foreach (text[k]) begin
            rec.code = text[k];
            rec.last = (k == text.size() - 1);
            expected_chars.push_back(rec);
        end
    endfunction

    function automatic logic [fda_pkg::VALUE_W-1:0] random_number();
        logic [fda_pkg::VALUE_W-1:0] v;

        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = {32'($urandom_range(99)), $urandom};
            2: v = {32'($urandom_range(9999)), $urandom};
            3: v = {$urandom, ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(3))};
            4: v = {32'd0, $urandom};
            default: v = {($urandom_range(1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000, $urandom};
        endcase
        if (($urandom_range(1) == 1) && ($urandom_range(5) != 0)) begin
            v = ~v + 64'd1;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("ERROR: number %0d, char %0d: %s", numbers_checked, char_pos, msg);
        end
        mismatch_count++;
    endtask

    task automatic wait_drained();
        while (numbers_to_send.size() != 0 || numbers_sent != numbers_accepted ||
               expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frac_digits(input logic [fda_pkg::CFG_W-1:0] digits);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= digits;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Input driver: a number stays offered until its transaction completes.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (numbers_sent == numbers_accepted) begin
            if (numbers_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_in_valid <= 1'b1;
                i_value    <= numbers_to_send.pop_front();
                numbers_sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_char_rec want;

        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                format_decimal(i_value, frac_cfg);
                numbers_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                frac_cfg = i_cfg_data;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h", o_char_code));
                end else begin
                    want = expected_chars.pop_front();
                    if (o_char_code !== want.code) begin
                        report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                                  o_char_code, want.code));
                    end
                    if (o_last !== want.last) begin
                        report_mismatch($sformatf("last %b, expected %b", o_last, want.last));
                    end
                end
                if (o_last === 1'b1) begin
                    numbers_checked++;
                    char_pos = 0;
                end else begin
                    char_pos++;
                end
            end
        end
    end

    // A long output stall while numbers keep coming fills the converter.
    initial begin
        @(posedge i_clk iff numbers_accepted >= 30);
        rx_hold = 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [fda_pkg::CFG_W-1:0] digits;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        numbers_to_send = '{
            64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h0000_0001_0000_0000, 64'hFFFF_FFFF_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
            64'h8000_0000_0000_0000, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_8000_0000,
            64'h0000_0000_FFFF_FFFF, 64'h0000_000A_0000_0000, 64'h4996_02D2_1F9A_DD37
        };
        wait_drained();

        write_frac_digits(4'd15);
        numbers_to_send = '{
            64'h0000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h0000_0003_243F_6A89, 64'hFFFF_FFFF_FFFF_FFFF
        };
        wait_drained();

        write_frac_digits(4'd0);
        numbers_to_send = '{
            64'h0000_0000_0000_0000, 64'h0000_0009_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF
        };
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase >= 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (phase >= 3) begin
                tx_idle_pct = 49;
                rx_idle_pct = 6;
            end
            case (phase)
                0, 6:    digits = 4'd0;
                1, 5:    digits = 4'd15;
                3:       digits = 4'd1;
                default: digits = 4'($urandom_range(15));
            endcase
            write_frac_digits(digits);
            repeat (NUMBERS_PER_PHASE) numbers_to_send.push_back(random_number());
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
